@@ sv/bfa_pkg.sv @@
// shared types and constants of the bitmap frame allocator
package bfa_pkg;

   localparam int DEF_MAP_WORDS = 1024;
   localparam int WORD_BITS     = 32;
   localparam int RESULT_LIMIT  = 32768;
   localparam int KIND_W        = 2;
   localparam int FRAME_W       = 15;
   localparam int COUNT_W       = 16;
   localparam int STATUS_W      = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_FREE    = 2'd1,
      KIND_RESERVE = 2'd2,
      KIND_QUERY   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_NO_SPACE     = 3'd1,
      ST_NULL_FREE    = 3'd2,
      ST_DOUBLE_FREE  = 3'd3,
      ST_OUT_OF_RANGE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_SEARCH,
      OP_MARK,
      OP_RELEASE,
      OP_QUERY
   } op_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_FILL,
      S_RUN,
      S_FLUSH,
      S_DONE
   } state_type;

endpackage

@@ sv/bfa_if.sv @@
// request and response channel interfaces of the bitmap frame allocator
interface bfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfa_pkg::KIND_W-1:0]    kind;
   logic [bfa_pkg::FRAME_W-1:0]   frame_index;
   logic [bfa_pkg::COUNT_W-1:0]   count;

   modport source (output valid, kind, frame_index, count, input ready);
   modport sink   (input valid, kind, frame_index, count, output ready);
endinterface

interface bfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfa_pkg::FRAME_W-1:0]   result_frame;
   logic [bfa_pkg::STATUS_W-1:0]  status;
   logic                          frame_free;

   modport source (output valid, result_frame, status, frame_free, input ready);
   modport sink   (input valid, result_frame, status, frame_free, output ready);
endinterface

@@ sv/bitmap_frame_allocator_top.sv @@
// bitmap frame allocator: usage bitmap memory and the frame-walking sequencer
//
// One request beat in on req_chan (alloc, free, reserve or query), one
// response beat out on rsp_chan. The usage bitmap sits in a single-port-write,
// registered-read memory of MAP_WORDS words of 32 frames each.
// After reset a clearing pass writes all ones (every frame used), one word per
// cycle, and req_chan.ready stays low until the pass is complete.
// One request is worked on at a time. A small sequencer walks one frame per
// cycle through a cached copy of the current word, pausing at each word
// boundary: each new word passes through a load and a fill step, and each
// dirty word through a write-back step. Alloc walks frames from 0 to the end
// of the first fitting run and then walks the run again to mark it. Rejected
// requests (alloc of zero or too many frames, free of frame 0) answer in the
// cycle after the request beat.
// The response is held in registers until rsp_chan.ready; the block takes no
// new request until the response beat has gone.
module bitmap_frame_allocator_top #(
   parameter int MAP_WORDS = bfa_pkg::DEF_MAP_WORDS
) (
   input  logic      clock,
   input  logic      reset,
   bfa_req_if.sink   req_chan,
   bfa_rsp_if.source rsp_chan
);

   localparam int TOTAL = MAP_WORDS * bfa_pkg::WORD_BITS;
   localparam int LIM   = (TOTAL < bfa_pkg::RESULT_LIMIT) ? TOTAL : bfa_pkg::RESULT_LIMIT;
   // frame cursor must hold first + count and the total
   localparam int FCW   = $clog2(TOTAL + 98304);
   localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CW    = bfa_pkg::COUNT_W;

   // bitmap memory
   logic [bfa_pkg::WORD_BITS-1:0] mem [MAP_WORDS];
   logic [bfa_pkg::WORD_BITS-1:0] rdata_ff;
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [bfa_pkg::WORD_BITS-1:0] mem_wdata;
   logic [AW-1:0]                 rd_addr;

   // sequencer state
   bfa_pkg::state_type            state_ff, state_in;
   bfa_pkg::op_type               op_ff, op_in;
   logic [FCW-1:0]                f_ff, f_in;
   logic [CW-1:0]                 k_ff, k_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 run_ff, run_in;
   logic [bfa_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic [AW-1:0]                 waddr_ff, waddr_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic                          cont_ff, cont_in;
   logic [bfa_pkg::FRAME_W-1:0]   res_frame_ff, res_frame_in;
   bfa_pkg::status_type           status_ff, status_in;
   logic                          free_ff, free_in;

   logic                          cur_bit;
   logic                          past_end;
   logic                          word_last;
   logic [FCW-1:0]                run_start;

   assign rd_addr   = f_ff[AW+4:5];
   assign cur_bit   = word_ff[f_ff[4:0]];
   assign past_end  = (f_ff >= FCW'(TOTAL));
   assign word_last = (f_ff[4:0] == 5'd31);
   assign run_start = f_ff + FCW'(1) - FCW'(count_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfa_pkg::S_CLEAR;
         clr_ff   <= '0;
         // cached word matches word 0 after the clearing pass
         word_ff  <= '1;
         waddr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         word_ff  <= word_in;
         waddr_ff <= waddr_in;
      end
      op_ff        <= op_in;
      f_ff         <= f_in;
      k_ff         <= k_in;
      count_ff     <= count_in;
      run_ff       <= run_in;
      cont_ff      <= cont_in;
      res_frame_ff <= res_frame_in;
      status_ff    <= status_in;
      free_ff      <= free_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      f_in         = f_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      run_in       = run_ff;
      word_in      = word_ff;
      waddr_in     = waddr_ff;
      clr_in       = clr_ff;
      cont_in      = cont_ff;
      res_frame_in = res_frame_ff;
      status_in    = status_ff;
      free_in      = free_ff;
      mem_we       = 1'b0;
      mem_waddr    = waddr_ff;
      mem_wdata    = word_ff;

      unique case (state_ff)
         bfa_pkg::S_CLEAR: begin
            // clearing pass: every frame marked used
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '1;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = bfa_pkg::S_IDLE;
            end
         end

         bfa_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               res_frame_in = '0;
               status_in    = bfa_pkg::ST_OK;
               free_in      = 1'b0;
               count_in     = req_chan.count;
               k_in         = '0;
               run_in       = '0;
               f_in         = FCW'(req_chan.frame_index);
               state_in     = bfa_pkg::S_LOAD;
               unique case (bfa_pkg::kind_type'(req_chan.kind))
                  bfa_pkg::KIND_ALLOC: begin
                     op_in = bfa_pkg::OP_SEARCH;
                     f_in  = '0;
                     if (req_chan.count == '0 || 17'(req_chan.count) > 17'(LIM)) begin
                        status_in = bfa_pkg::ST_NO_SPACE;
                        state_in  = bfa_pkg::S_DONE;
                     end
                  end
                  bfa_pkg::KIND_FREE: begin
                     op_in = bfa_pkg::OP_RELEASE;
                     if (req_chan.frame_index == '0) begin
                        status_in = bfa_pkg::ST_NULL_FREE;
                        state_in  = bfa_pkg::S_DONE;
                     end
                  end
                  bfa_pkg::KIND_RESERVE: op_in = bfa_pkg::OP_MARK;
                  bfa_pkg::KIND_QUERY:   op_in = bfa_pkg::OP_QUERY;
                  default:               op_in = bfa_pkg::OP_QUERY;
               endcase
            end
         end

         bfa_pkg::S_LOAD: begin
            // nothing to fetch past the end; the run step stops there
            if (past_end) begin
               state_in = bfa_pkg::S_RUN;
            end else begin
               waddr_in = rd_addr;
               state_in = bfa_pkg::S_FILL;
            end
         end

         bfa_pkg::S_FILL: begin
            word_in  = rdata_ff;
            state_in = bfa_pkg::S_RUN;
         end

         bfa_pkg::S_RUN: begin
            unique case (op_ff)
               bfa_pkg::OP_QUERY: begin
                  if (past_end) begin
                     status_in = bfa_pkg::ST_OUT_OF_RANGE;
                  end else begin
                     free_in = ~cur_bit;
                  end
                  state_in = bfa_pkg::S_DONE;
               end

               bfa_pkg::OP_SEARCH: begin
                  if (f_ff >= FCW'(LIM)) begin
                     status_in = bfa_pkg::ST_NO_SPACE;
                     state_in  = bfa_pkg::S_DONE;
                  end else if (cur_bit) begin
                     run_in = '0;
                     f_in   = f_ff + FCW'(1);
                     if (word_last) state_in = bfa_pkg::S_LOAD;
                  end else if (17'(run_ff) + 17'd1 == 17'(count_ff)) begin
                     // run found: walk it again and mark it
                     res_frame_in = run_start[bfa_pkg::FRAME_W-1:0];
                     f_in         = run_start;
                     k_in         = '0;
                     op_in        = bfa_pkg::OP_MARK;
                     state_in     = bfa_pkg::S_LOAD;
                  end else begin
                     run_in = run_ff + CW'(1);
                     f_in   = f_ff + FCW'(1);
                     if (word_last) state_in = bfa_pkg::S_LOAD;
                  end
               end

               default: begin
                  // mark or release one frame per cycle, pausing at word boundaries
                  cont_in = 1'b0;
                  if (k_ff == count_ff) begin
                     state_in = bfa_pkg::S_FLUSH;
                  end else if (past_end) begin
                     status_in = bfa_pkg::ST_OUT_OF_RANGE;
                     state_in  = bfa_pkg::S_FLUSH;
                  end else if (op_ff == bfa_pkg::OP_RELEASE && !cur_bit) begin
                     status_in = bfa_pkg::ST_DOUBLE_FREE;
                     state_in  = bfa_pkg::S_FLUSH;
                  end else begin
                     word_in[f_ff[4:0]] = (op_ff == bfa_pkg::OP_MARK);
                     k_in = k_ff + CW'(1);
                     f_in = f_ff + FCW'(1);
                     if (word_last) begin
                        cont_in  = 1'b1;
                        state_in = bfa_pkg::S_FLUSH;
                     end
                  end
               end
            endcase
         end

         bfa_pkg::S_FLUSH: begin
            mem_we   = 1'b1;
            state_in = cont_ff ? bfa_pkg::S_LOAD : bfa_pkg::S_DONE;
         end

         bfa_pkg::S_DONE: begin
            if (rsp_chan.ready) begin
               state_in = bfa_pkg::S_IDLE;
            end
         end

         default: state_in = bfa_pkg::S_IDLE;
      endcase
   end

   assign req_chan.ready        = (state_ff == bfa_pkg::S_IDLE);
   assign rsp_chan.valid        = (state_ff == bfa_pkg::S_DONE);
   assign rsp_chan.result_frame = res_frame_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.frame_free   = free_ff;

endmodule
